### rtl/vsts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the volume store / trilinear sampler.
// No dependencies; every other file but vsts_ram imports this package.
package vsts_pkg;

    localparam int DIM_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int COORD_W   = 16;
    localparam int VALUE_W   = 16;
    localparam int SAMPLE_W  = 24;
    localparam int SLICE_W   = 6;
    localparam int OFFSET_W  = 12;
    localparam int OUT_FRAC  = 8;
    localparam int CORNER_W  = 3;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 2'd2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd7;

    typedef struct packed {
        logic                       opcode;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic signed [COORD_W-1:0]  coord_z;
        logic [SLICE_W-1:0]         slice_index;
        logic [OFFSET_W-1:0]        slice_offset;
        logic [VALUE_W-1:0]         voxel_value;
    } t_item;

    typedef struct packed {
        logic                accept;
        logic                load;
        logic                addr;
        logic                wr_commit;
        logic                rd_issue;
        logic [CORNER_W-1:0] corner;
        logic                clr_step;
        logic                out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic pipe_empty;
        logic out_free;
        logic is_sample;
    } t_sts;

endpackage

### rtl/vsts_in_if.sv
`timescale 1ns / 1ps
// Input channel of the sampler: valid/ready plus one item payload.
// Depends on vsts_pkg.
interface vsts_in_if;
    import vsts_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [SLICE_W-1:0]        slice_index;
    logic [OFFSET_W-1:0]       slice_offset;
    logic [VALUE_W-1:0]        voxel_value;

    modport source (output valid, opcode, coord_x, coord_y, coord_z, slice_index,
                    slice_offset, voxel_value, input ready);
    modport sink   (input valid, opcode, coord_x, coord_y, coord_z, slice_index,
                    slice_offset, voxel_value, output ready);
endinterface

### rtl/vsts_out_if.sv
`timescale 1ns / 1ps
// Output channel of the sampler: valid/ready plus one result payload.
// Depends on vsts_pkg.
interface vsts_out_if;
    import vsts_pkg::*;
    logic                valid;
    logic                ready;
    logic                status;
    logic [SAMPLE_W-1:0] sample_value;

    modport source (output valid, status, sample_value, input ready);
    modport sink   (input valid, status, sample_value, output ready);
endinterface

### rtl/volume_store_trilinear_sampler_top.sv
`timescale 1ns / 1ps
// Sampler top: a write stores one voxel, passing through the load, address, write and
// done states before its result is loaded; a sample reads eight neighbours one per cycle
// from the single-read voxel RAM, drains the accumulate pipeline, then loads its result.
// The next item is taken only after the last result is loaded; a result that waits on
// the sink holds off the next item. Reset: synchronous, active low; after reset a clear
// sweep writes zero to every voxel, one per cycle, before items are taken.
module volume_store_trilinear_sampler_top #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_DEPTH  = 64,
    parameter int FRAC_BITS  = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vsts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vsts_pkg::DIM_W-1:0]      i_cfg_data,
    vsts_in_if.sink                         i_item,
    vsts_out_if.source                      o_result
);
    import vsts_pkg::*;

    t_item w_item;
    t_cmd  w_cmd;
    t_sts  w_sts;
    logic  w_in_ready;

    // Pack the incoming beat into one item word for the datapath.
    always_comb begin
        w_item.opcode       = i_item.opcode;
        w_item.coord_x      = i_item.coord_x;
        w_item.coord_y      = i_item.coord_y;
        w_item.coord_z      = i_item.coord_z;
        w_item.slice_index  = i_item.slice_index;
        w_item.slice_offset = i_item.slice_offset;
        w_item.voxel_value  = i_item.voxel_value;
    end

    assign i_item.ready = w_in_ready;

    // Controller sequences clear sweep, address setup, the eight corner reads
    // and the hand-off into the result register.
    vsts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath holds the config registers, voxel RAM and the result register;
    // the result beat waits there until the sink takes it.
    vsts_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_DEPTH  (MAX_DEPTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_status    (o_result.status),
        .o_sample    (o_result.sample_value)
    );
endmodule

### rtl/vsts_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vsts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/vsts_datapath.sv
`timescale 1ns / 1ps
// Datapath: config registers, axis split, address math, voxel RAM,
// weighted accumulate pipeline and result register. Depends on vsts_pkg, vsts_ram.
module vsts_datapath #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_DEPTH  = 64,
    parameter int FRAC_BITS  = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vsts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vsts_pkg::DIM_W-1:0]        i_cfg_data,
    input  vsts_pkg::t_item                   i_item,
    input  vsts_pkg::t_cmd                    i_cmd,
    output vsts_pkg::t_sts                    o_sts,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_status,
    output logic [vsts_pkg::SAMPLE_W-1:0]     o_sample
);
    import vsts_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (AW > 3 * DIM_W) ? AW : 3 * DIM_W;
    localparam int VW    = DIM_W + FRAC_BITS;
    localparam int CLW   = ((COORD_W > VW) ? COORD_W : VW) + 1;
    localparam int WW    = FRAC_BITS + 1;
    localparam int PW    = VALUE_W + 3 * WW;
    localparam int ACW   = PW + 3;
    localparam int SHIFT = 3 * FRAC_BITS - OUT_FRAC;

    function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] r,
                                                 input logic [8:0] mx);
        if (r == '0) begin
            return DIM_W'(1);
        end else if ({2'b00, r} > mx) begin
            return mx[DIM_W-1:0];
        end else begin
            return r;
        end
    endfunction

    function automatic logic [VW-1:0] clamp_coord(input logic signed [COORD_W-1:0] c,
                                                  input logic [DIM_W-1:0] n);
        logic signed [CLW-1:0] cv;
        logic signed [CLW-1:0] top;
        cv  = CLW'(c);
        top = $signed({{(CLW-VW){1'b0}}, n - 1'b1, {FRAC_BITS{1'b0}}});
        if (cv < 0) begin
            return '0;
        end else if (cv > top) begin
            return top[VW-1:0];
        end else begin
            return cv[VW-1:0];
        end
    endfunction

    function automatic logic [DIM_W-1:0] upper(input logic [DIM_W-1:0] lo,
                                               input logic [DIM_W-1:0] n);
        logic [DIM_W-1:0] nx;
        nx = lo + DIM_W'(1);
        return (nx < n) ? nx : n - DIM_W'(1);
    endfunction

    // configuration
    logic [DIM_W-1:0] r_cfg_w, r_cfg_h, r_cfg_d;
    logic [DIM_W-1:0] w_we, w_he, w_de;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= DIM_RESET;
            r_cfg_h <= DIM_RESET;
            r_cfg_d <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_cfg_w <= i_cfg_data;
                REG_HEIGHT: r_cfg_h <= i_cfg_data;
                REG_DEPTH:  r_cfg_d <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    assign w_we = dim_eff(r_cfg_w, 9'(MAX_WIDTH));
    assign w_he = dim_eff(r_cfg_h, 9'(MAX_HEIGHT));
    assign w_de = dim_eff(r_cfg_d, 9'(MAX_DEPTH));

    // item latch
    t_item r_item;
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_item;
        end
    end

    // axis split
    logic [VW-1:0] w_vx, w_vy, w_vz;
    assign w_vx = clamp_coord(r_item.coord_x, w_we);
    assign w_vy = clamp_coord(r_item.coord_y, w_he);
    assign w_vz = clamp_coord(r_item.coord_z, w_de);

    logic [DIM_W-1:0]   r_xs [2];
    logic [DIM_W-1:0]   r_ys [2];
    logic [DIM_W-1:0]   r_zs [2];
    logic [WW-1:0]      r_wx [2];
    logic [WW-1:0]      r_wy [2];
    logic [WW-1:0]      r_wz [2];
    logic [DIM_W-1:0]   r_w, r_d;
    logic [2*DIM_W-1:0] r_wh;
    localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w     <= w_we;
            r_d     <= w_de;
            r_wh    <= (2*DIM_W)'(w_we) * (2*DIM_W)'(w_he);
            r_xs[0] <= w_vx[VW-1:FRAC_BITS];
            r_ys[0] <= w_vy[VW-1:FRAC_BITS];
            r_zs[0] <= w_vz[VW-1:FRAC_BITS];
            r_xs[1] <= upper(w_vx[VW-1:FRAC_BITS], w_we);
            r_ys[1] <= upper(w_vy[VW-1:FRAC_BITS], w_he);
            r_zs[1] <= upper(w_vz[VW-1:FRAC_BITS], w_de);
            r_wx[1] <= WW'(w_vx[FRAC_BITS-1:0]);
            r_wy[1] <= WW'(w_vy[FRAC_BITS-1:0]);
            r_wz[1] <= WW'(w_vz[FRAC_BITS-1:0]);
            r_wx[0] <= ONE - WW'(w_vx[FRAC_BITS-1:0]);
            r_wy[0] <= ONE - WW'(w_vy[FRAC_BITS-1:0]);
            r_wz[0] <= ONE - WW'(w_vz[FRAC_BITS-1:0]);
        end
    end

    // address bases and write check
    logic [SW-1:0] r_zb [2];
    logic [SW-1:0] r_yb [2];
    logic [SW-1:0] r_wbase;
    logic          r_rej;

    always_ff @(posedge i_clk) begin
        if (i_cmd.addr) begin
            r_zb[0] <= SW'(r_zs[0]) * SW'(r_wh);
            r_zb[1] <= SW'(r_zs[1]) * SW'(r_wh);
            r_yb[0] <= SW'(r_ys[0]) * SW'(r_w);
            r_yb[1] <= SW'(r_ys[1]) * SW'(r_w);
            r_wbase <= SW'(r_item.slice_index) * SW'(r_wh);
            r_rej   <= ({1'b0, r_item.slice_index} >= r_d) ||
                       ({2'b00, r_item.slice_offset} >= r_wh);
        end
    end

    // clear sweep
    logic [AW-1:0] r_clr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // voxel memory
    logic              w_ram_we;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [VALUE_W-1:0] w_wdata, w_rdata;
    logic [SW-1:0]     w_wsum, w_rsum;
    logic              w_ci, w_cj, w_ck;

    assign w_ci     = i_cmd.corner[0];
    assign w_cj     = i_cmd.corner[1];
    assign w_ck     = i_cmd.corner[2];
    assign w_wsum   = r_wbase + SW'(r_item.slice_offset);
    assign w_rsum   = r_zb[w_ck] + r_yb[w_cj] + SW'(r_xs[w_ci]);
    assign w_raddr  = w_rsum[AW-1:0];
    assign w_ram_we = i_cmd.clr_step || (i_cmd.wr_commit && !r_rej);
    assign w_waddr  = i_cmd.clr_step ? r_clr : w_wsum[AW-1:0];
    assign w_wdata  = i_cmd.clr_step ? '0 : r_item.voxel_value;

    vsts_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // weight/accumulate pipeline
    logic               r_p1_vld, r_p2_vld, r_p3_vld;
    logic               r_p1_k;
    logic [2*WW-1:0]    r_wxy;
    logic [3*WW-1:0]    r_w3;
    logic [VALUE_W-1:0] r_dat;
    logic [PW-1:0]      r_prod;
    logic [ACW-1:0]     r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
        end else begin
            r_p1_vld <= i_cmd.rd_issue;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wxy  <= (2*WW)'(r_wx[w_ci]) * (2*WW)'(r_wy[w_cj]);
        r_p1_k <= w_ck;
        r_w3   <= (3*WW)'(r_wxy) * (3*WW)'(r_wz[r_p1_k]);
        r_dat  <= w_rdata;
        r_prod <= PW'(r_dat) * PW'(r_w3);
        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (r_p3_vld) begin
            r_acc <= r_acc + ACW'(r_prod);
        end
    end

    // round to nearest, ties up
    logic [ACW:0] w_rnd;
    assign w_rnd = {1'b0, r_acc} + ((ACW+1)'(1) << (SHIFT - 1));

    // result register
    logic                r_ovld;
    logic                r_ostat;
    logic [SAMPLE_W-1:0] r_osamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovld <= 1'b1;
        end else if (i_out_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_item.opcode == OP_SAMPLE) begin
                r_ostat <= STATUS_OK;
                r_osamp <= w_rnd[SHIFT+SAMPLE_W-1:SHIFT];
            end else begin
                r_ostat <= r_rej ? STATUS_REJECT : STATUS_OK;
                r_osamp <= '0;
            end
        end
    end

    assign o_out_valid      = r_ovld;
    assign o_status         = r_ostat;
    assign o_sample         = r_osamp;
    assign o_sts.clr_last   = (r_clr == AW'(DEPTH - 1));
    assign o_sts.pipe_empty = !(r_p1_vld || r_p2_vld || r_p3_vld);
    assign o_sts.out_free   = !r_ovld || i_out_ready;
    assign o_sts.is_sample  = (r_item.opcode == OP_SAMPLE);
endmodule

### rtl/vsts_ctrl.sv
`timescale 1ns / 1ps
// Controller: clear sweep, item sequencing and corner read issue.
// Depends on vsts_pkg.
module vsts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  vsts_pkg::t_sts i_sts,
    output vsts_pkg::t_cmd o_cmd
);
    import vsts_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_ADDR  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]          r_state, n_state;
    logic [CORNER_W-1:0] r_corner, n_corner;

    always_comb begin
        n_state  = r_state;
        n_corner = r_corner;
        o_cmd    = '0;
        o_cmd.corner = r_corner;
        o_in_ready   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.addr = 1'b1;
                n_corner   = '0;
                n_state    = i_sts.is_sample ? S_READ : S_WRITE;
            end
            S_WRITE: begin
                o_cmd.wr_commit = 1'b1;
                n_state         = S_DONE;
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_corner       = r_corner + CORNER_W'(1);
                if (r_corner == LAST_CORNER) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_corner <= '0;
        end else begin
            r_state  <= n_state;
            r_corner <= n_corner;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("item taken during clear sweep");
    a_last_corner_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && r_corner == LAST_CORNER) |=> (r_state == S_DRAIN))
        else $error("corner sequence did not end after eight reads");
    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over an untaken result");
    a_done_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && $past(r_state) == S_DRAIN) |-> i_sts.pipe_empty)
        else $error("result formed before accumulate pipeline emptied");
`endif
endmodule

### tb/vsts_sample_checker.sv
`timescale 1ns / 1ps
// Checker for the volume store / trilinear sampler: mirrors the voxel store and
// dimension registers, predicts each result and compares. Depends on vsts_pkg and the channel interfaces.
module vsts_sample_checker #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_DEPTH  = 64,
    parameter int FRAC_BITS  = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vsts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vsts_pkg::DIM_W-1:0]     i_cfg_data,
    vsts_in_if                             item_ch,
    vsts_out_if                            result_ch,
    output int                             o_errors,
    output int                             o_pending
);
    import vsts_pkg::*;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_DEPTH;

    typedef struct {
        logic                status;
        logic [SAMPLE_W-1:0] value;
    } t_result;

    t_result          expected_results[$];
    logic [VALUE_W-1:0] voxels [0:STORE_DEPTH-1];
    logic [DIM_W-1:0] width_reg, height_reg, depth_reg;
    int               error_count = 0;

    assign o_errors = error_count;

    initial begin
        foreach (voxels[i]) voxels[i] = '0;
    end

    function automatic int unsigned dim_used(logic [DIM_W-1:0] r, int unsigned maxv);
        if (r == 0) return 1;
        if (r > maxv) return maxv;
        return r;
    endfunction

    // Clamp to [0, n-1] and split into lower/upper neighbour and fraction.
    function automatic void split_axis(input logic signed [COORD_W-1:0] c, input int unsigned n,
                                       output int unsigned lo, output int unsigned hi,
                                       output int unsigned frac);
        int v;
        int top;
        top = (n - 1) << FRAC_BITS;
        v = c;
        if (v < 0) v = 0;
        if (v > top) v = top;
        lo = v >> FRAC_BITS;
        frac = v & ((1 << FRAC_BITS) - 1);
        hi = (lo + 1 < n) ? lo + 1 : n - 1;
    endfunction

    // Apply one item to the mirrored store and return the result it causes.
    function automatic t_result apply_item(t_item it);
        t_result r;
        int unsigned w, h, d;
        int unsigned xs[2], ys[2], zs[2];
        int unsigned tx, ty, tz;
        longint unsigned wx[2], wy[2], wz[2];
        longint unsigned sum;
        int unsigned one, shift;
        w = dim_used(width_reg, MAX_WIDTH);
        h = dim_used(height_reg, MAX_HEIGHT);
        d = dim_used(depth_reg, MAX_DEPTH);
        r.status = STATUS_OK;
        r.value  = '0;
        if (it.opcode == OP_WRITE) begin
            if (it.slice_index >= d || it.slice_offset >= w * h) begin
                r.status = STATUS_REJECT;
            end else begin
                voxels[it.slice_index * w * h + it.slice_offset] = it.voxel_value;
            end
            return r;
        end
        one   = 1 << FRAC_BITS;
        shift = 3 * FRAC_BITS - OUT_FRAC;
        split_axis(it.coord_x, w, xs[0], xs[1], tx);
        split_axis(it.coord_y, h, ys[0], ys[1], ty);
        split_axis(it.coord_z, d, zs[0], zs[1], tz);
        wx[0] = one - tx; wx[1] = tx;
        wy[0] = one - ty; wy[1] = ty;
        wz[0] = one - tz; wz[1] = tz;
        sum = 0;
        for (int k = 0; k < 2; k++)
            for (int j = 0; j < 2; j++)
                for (int i = 0; i < 2; i++)
                    sum += longint'(voxels[zs[k] * w * h + ys[j] * w + xs[i]])
                           * wx[i] * wy[j] * wz[k];
        sum = (sum + (64'd1 << (shift - 1))) >> shift;
        r.value = sum[SAMPLE_W-1:0];
        return r;
    endfunction

    task automatic report(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_item   it;
        t_result want;
        if (!i_rst_n) begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
            depth_reg  <= DIM_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WIDTH:  width_reg  <= i_cfg_data;
                    REG_HEIGHT: height_reg <= i_cfg_data;
                    REG_DEPTH:  depth_reg  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (result_ch.valid && result_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (result_ch.status !== want.status)
                        report($sformatf("status got %0b want %0b",
                                         result_ch.status, want.status));
                    if (result_ch.sample_value !== want.value)
                        report($sformatf("sample_value got %h want %h",
                                         result_ch.sample_value, want.value));
                end
            end
            if (item_ch.valid && item_ch.ready) begin
                it.opcode       = item_ch.opcode;
                it.coord_x      = item_ch.coord_x;
                it.coord_y      = item_ch.coord_y;
                it.coord_z      = item_ch.coord_z;
                it.slice_index  = item_ch.slice_index;
                it.slice_offset = item_ch.slice_offset;
                it.voxel_value  = item_ch.voxel_value;
                expected_results.push_back(apply_item(it));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the sampler testbench: clock, reset, stimulus and verdict.
// Depends on vsts_pkg, the channel interfaces, the sampler top and vsts_sample_checker.
module testbench;
    import vsts_pkg::*;

    // A clear sweep of the whole store follows reset, so the quiet-cycle
    // limit must outlast the sweep with room to spare.
    localparam int QUIET_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int NUM_PHASES = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0] cfg_data;
    int               errors;
    int               pending;
    int               idle_pct;
    int               stall_pct;
    int               quiet_cycles = 0;
    int unsigned      cur_w, cur_h, cur_d;

    vsts_in_if  item_ch ();
    vsts_out_if result_ch ();

    volume_store_trilinear_sampler_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    vsts_sample_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .item_ch     (item_ch),
        .result_ch   (result_ch),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver side: drop ready at random according to the phase's stall rate.
    always @(posedge i_clk) begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int unsigned dim_used(logic [DIM_W-1:0] r);
        if (r == 0) return 1;
        if (r > 64) return 64;
        return r;
    endfunction

    // Hold a beat on the input channel until it is taken; idle first at random.
    task automatic send_item(t_item it);
        while ($urandom_range(99) < idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.opcode       <= it.opcode;
        item_ch.coord_x      <= it.coord_x;
        item_ch.coord_y      <= it.coord_y;
        item_ch.coord_z      <= it.coord_z;
        item_ch.slice_index  <= it.slice_index;
        item_ch.slice_offset <= it.slice_offset;
        item_ch.voxel_value  <= it.voxel_value;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    task automatic send_write(int slice, int offset, int value);
        t_item it;
        it = t_item'($bits(t_item)'({$urandom, $urandom, $urandom}));
        it.opcode       = OP_WRITE;
        it.slice_index  = SLICE_W'(slice);
        it.slice_offset = OFFSET_W'(offset);
        it.voxel_value  = VALUE_W'(value);
        send_item(it);
    endtask

    task automatic send_sample(int x, int y, int z);
        t_item it;
        it = t_item'($bits(t_item)'({$urandom, $urandom, $urandom}));
        it.opcode  = OP_SAMPLE;
        it.coord_x = COORD_W'(x);
        it.coord_y = COORD_W'(y);
        it.coord_z = COORD_W'(z);
        send_item(it);
    endtask

    // Coordinate mostly inside the volume, with a little overhang on both sides.
    function automatic logic signed [COORD_W-1:0] near_coord(int unsigned n);
        int c;
        c = int'($urandom_range(0, n * 256 + 256)) - 128;
        return COORD_W'(c);
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    pick;
        it = t_item'($bits(t_item)'({$urandom, $urandom, $urandom}));
        pick = $urandom_range(99);
        if (pick < 45) begin
            // well-formed write, often at full scale
            it.opcode       = OP_WRITE;
            it.slice_index  = SLICE_W'($urandom_range(0, cur_d - 1));
            it.slice_offset = OFFSET_W'($urandom_range(0, cur_w * cur_h - 1));
            if ($urandom_range(3) == 0) it.voxel_value = '1;
        end else if (pick < 52) begin
            it.opcode = OP_WRITE;  // raw fields, often rejected
        end else if (pick < 92) begin
            it.opcode  = OP_SAMPLE;
            it.coord_x = near_coord(cur_w);
            it.coord_y = near_coord(cur_h);
            it.coord_z = near_coord(cur_d);
        end else begin
            it.opcode = OP_SAMPLE;  // raw coordinates, mostly clamped
        end
        return it;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // Drain the block, then write the three dimension registers.
    task automatic set_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, logic [DIM_W-1:0] d);
        item_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_DEPTH, d);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        cur_w = dim_used(w);
        cur_h = dim_used(h);
        cur_d = dim_used(d);
    endtask

    logic [DIM_W-1:0] phase_w [NUM_PHASES] = '{7'd64, 7'd0, 7'd1, 7'd5, 7'd127, 7'd2, 7'd8, 7'd63};
    logic [DIM_W-1:0] phase_h [NUM_PHASES] = '{7'd64, 7'd127, 7'd1, 7'd7, 7'd0, 7'd2, 7'd4, 7'd64};
    logic [DIM_W-1:0] phase_d [NUM_PHASES] = '{7'd64, 7'd3, 7'd1, 7'd2, 7'd64, 7'd2, 7'd3, 7'd1};
    int idle_modes  [4] = '{0, 76, 0, 16};
    int stall_modes [4] = '{0, 0, 76, 16};

    initial begin
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= REG_WIDTH;
        cfg_data             <= '0;
        item_ch.valid        <= 1'b0;
        item_ch.opcode       <= OP_WRITE;
        item_ch.coord_x      <= '0;
        item_ch.coord_y      <= '0;
        item_ch.coord_z      <= '0;
        item_ch.slice_index  <= '0;
        item_ch.slice_offset <= '0;
        item_ch.voxel_value  <= '0;
        idle_pct  = 0;
        stall_pct = 0;
        cur_w = 64;
        cur_h = 64;
        cur_d = 64;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, full-size volume: a full-scale cube at the origin and one voxel at the far corner.
        send_write(0, 0, 16'hFFFF);
        send_write(0, 1, 16'hFFFF);
        send_write(0, 64, 16'hFFFF);
        send_write(0, 65, 16'hFFFF);
        send_write(1, 0, 16'hFFFF);
        send_write(1, 1, 16'hFFFF);
        send_write(1, 64, 16'hFFFF);
        send_write(1, 65, 16'hFFFF);
        send_write(63, 4095, 16'h1234);
        send_sample(16'h0080, 16'h0080, 16'h0080);
        send_sample(0, 0, 0);
        send_sample(-32768, -32768, -32768);
        send_sample(32767, 32767, 32767);
        send_sample(16'h00FF, 16'h0001, 16'h0180);
        send_sample(16'h3F80, 16'h0040, 16'hFFFF);

        // Degenerate dimensions: zero used as one, oversize used as the maximum.
        set_dims(7'd0, 7'd127, 7'd3);
        write_reg(REG_SPARE, 7'd5);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        send_write(3, 0, 16'hAAAA);
        send_write(0, 64, 16'h5555);
        send_write(63, 4095, 16'h0F0F);
        send_write(2, 63, 16'h8001);
        send_write(0, 0, 16'h0000);
        send_sample(16'h0180, 16'h3F80, 16'h0200);
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF);

        // Random phases, rotating through the idle and stall modes and the dimension settings.
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_dims(phase_w[p], phase_h[p], phase_d[p]);
            idle_pct  = idle_modes[p % 4];
            stall_pct = stall_modes[p % 4];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(random_item());
        end

        item_ch.valid <= 1'b0;
        stall_pct = 0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
